// ===== design/sorted_array_table_assert.svh =====
// Assertion macros shared by the table RTL.
// Each macro checks on the rising edge of clk and is off while rst_n is low.
`ifndef SORTED_ARRAY_TABLE_ASSERT_SVH
`define SORTED_ARRAY_TABLE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SAT_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted_array_table: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SAT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted_array_table: next-cycle check failed");

`endif

// ===== design/sat_pkg.sv =====
package sat_pkg;

    localparam logic [2:0] CMD_INSERT     = 3'd0;
    localparam logic [2:0] CMD_SEARCH     = 3'd1;
    localparam logic [2:0] CMD_REMOVE     = 3'd2;
    localparam logic [2:0] CMD_REMOVE_MAX = 3'd3;
    localparam logic [2:0] CMD_REMOVE_MIN = 3'd4;
    localparam logic [2:0] CMD_CLEAR      = 3'd5;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_EMPTY     = 2'd3;

    typedef struct packed {
        logic [2:0]         cmd;
        logic signed [31:0] key;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [5:0]         position;
        logic signed [31:0] value;
        logic [6:0]         entry_count;
        logic signed [31:0] smallest;
        logic signed [31:0] largest;
    } rsp_t;

endpackage

// ===== design/sorted_array_table.sv =====
// Sorted key table. A request is taken when start is high while busy is low; the
// block then stays busy until its single result appears on result with done high
// for exactly one cycle, and the receiver cannot stall it. All keys live in one
// table memory with one registered read port and one write port, and a small
// sequencer walks it: finding the leftmost place reads and compares each entry in
// turn, and each entry moved by an insert or a removal is read and then written.
// Clear, a refused insert, an empty remove and remove max do no search or moves.
// After reset the table is empty and ready at once.
module sorted_array_table #(
    parameter int CAPACITY = 64
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  sat_pkg::req_t   request,
    output logic            busy,
    output logic            done,
    output sat_pkg::rsp_t   result
);
    import sat_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SCAN   = 4'd1;
    localparam logic [3:0] S_CMP    = 4'd2;
    localparam logic [3:0] S_LBDONE = 4'd3;
    localparam logic [3:0] S_SHUP   = 4'd4;
    localparam logic [3:0] S_SHUP_W = 4'd5;
    localparam logic [3:0] S_SHDN   = 4'd6;
    localparam logic [3:0] S_SHDN_W = 4'd7;
    localparam logic [3:0] S_GETV   = 4'd8;
    localparam logic [3:0] S_TAKEV  = 4'd9;
    localparam logic [3:0] S_FIN    = 4'd10;
    localparam logic [3:0] S_FIN1   = 4'd11;
    localparam logic [3:0] S_FIN2   = 4'd12;

    localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

    logic [31:0] mem [CAPACITY];

    logic [3:0]         state_reg, state_next;
    logic [2:0]         cmd_reg, cmd_next;
    logic signed [31:0] key_reg, key_next;
    logic [CW-1:0]      idx_reg, idx_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      pos_reg, pos_next;
    logic [1:0]         status_reg, status_next;
    logic [31:0]        value_reg, value_next;
    logic [31:0]        min_reg, min_next;
    logic [31:0]        max_reg, max_next;
    logic               found_reg, found_next;
    logic               done_reg, done_next;
    logic [31:0]        rdata_reg;

    logic [AW-1:0] rd_addr;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [31:0]   mem_wdata;

    logic [CW:0]   idx_inc;
    logic [CW-1:0] idx_dec;
    logic [CW-1:0] cnt_dec;

    assign idx_inc = {1'b0, idx_reg} + 1'b1;
    assign idx_dec = idx_reg - 1'b1;
    assign cnt_dec = count_reg - 1'b1;

    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        key_next    = key_reg;
        idx_next    = idx_reg;
        count_next  = count_reg;
        pos_next    = pos_reg;
        status_next = status_reg;
        value_next  = value_reg;
        min_next    = min_reg;
        max_next    = max_reg;
        found_next  = found_reg;
        done_next   = 1'b0;
        rd_addr     = '0;
        mem_we      = 1'b0;
        mem_waddr   = idx_reg[AW-1:0];
        mem_wdata   = rdata_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next    = request.cmd;
                    key_next    = request.key;
                    status_next = ST_OK;
                    pos_next    = '0;
                    value_next  = '0;
                    idx_next    = '0;
                    found_next  = 1'b0;
                    case (request.cmd)
                        CMD_INSERT:
                        begin
                            if (count_reg == CAP_CNT)
                            begin
                                status_next = ST_FULL;
                                state_next  = S_FIN;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        CMD_SEARCH, CMD_REMOVE:
                        begin
                            state_next = S_SCAN;
                        end
                        CMD_REMOVE_MAX, CMD_REMOVE_MIN:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                                state_next  = S_FIN;
                            end
                            else
                            begin
                                if (request.cmd == CMD_REMOVE_MAX)
                                begin
                                    count_next = cnt_dec;
                                    pos_next   = cnt_dec;
                                end
                                state_next = S_GETV;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            count_next = '0;
                            state_next = S_FIN;
                        end
                        default:
                        begin
                            state_next = S_FIN;
                        end
                    endcase
                end
            end

            // Linear lower-bound search: stop at the first entry not below the key.
            S_SCAN:
            begin
                if (idx_reg == count_reg)
                begin
                    found_next = 1'b0;
                    state_next = S_LBDONE;
                end
                else
                begin
                    rd_addr    = idx_reg[AW-1:0];
                    state_next = S_CMP;
                end
            end

            S_CMP:
            begin
                if ($signed(rdata_reg) < key_reg)
                begin
                    idx_next   = idx_inc[CW-1:0];
                    state_next = S_SCAN;
                end
                else
                begin
                    found_next = (rdata_reg == key_reg);
                    state_next = S_LBDONE;
                end
            end

            S_LBDONE:
            begin
                case (cmd_reg)
                    CMD_INSERT:
                    begin
                        pos_next   = idx_reg;
                        idx_next   = count_reg;
                        state_next = S_SHUP;
                    end
                    CMD_SEARCH:
                    begin
                        if (found_reg)
                        begin
                            pos_next = idx_reg;
                        end
                        else
                        begin
                            status_next = ST_NOT_FOUND;
                        end
                        state_next = S_FIN;
                    end
                    CMD_REMOVE:
                    begin
                        if (found_reg)
                        begin
                            pos_next   = idx_reg;
                            state_next = S_SHDN;
                        end
                        else
                        begin
                            status_next = ST_NOT_FOUND;
                            state_next  = S_FIN;
                        end
                    end
                    default:
                    begin
                        state_next = S_FIN;
                    end
                endcase
            end

            // Move entries up from the top down to the insert point, then drop the key in.
            S_SHUP:
            begin
                if (idx_reg == pos_reg)
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = pos_reg[AW-1:0];
                    mem_wdata  = key_reg;
                    count_next = idx_inc[CW-1:0] + (count_reg - idx_reg);
                    state_next = S_FIN;
                end
                else
                begin
                    rd_addr    = idx_dec[AW-1:0];
                    state_next = S_SHUP_W;
                end
            end

            S_SHUP_W:
            begin
                mem_we     = 1'b1;
                mem_waddr  = idx_reg[AW-1:0];
                idx_next   = idx_dec;
                state_next = S_SHUP;
            end

            // Close the gap at idx by pulling later entries down one place.
            S_SHDN:
            begin
                if (idx_inc >= {1'b0, count_reg})
                begin
                    count_next = cnt_dec;
                    state_next = S_FIN;
                end
                else
                begin
                    rd_addr    = idx_inc[AW-1:0];
                    state_next = S_SHDN_W;
                end
            end

            S_SHDN_W:
            begin
                mem_we     = 1'b1;
                mem_waddr  = idx_reg[AW-1:0];
                idx_next   = idx_inc[CW-1:0];
                state_next = S_SHDN;
            end

            S_GETV:
            begin
                rd_addr    = (cmd_reg == CMD_REMOVE_MAX) ? pos_reg[AW-1:0] : '0;
                state_next = S_TAKEV;
            end

            S_TAKEV:
            begin
                value_next = rdata_reg;
                if (cmd_reg == CMD_REMOVE_MAX)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    idx_next   = '0;
                    state_next = S_SHDN;
                end
            end

            // Refresh the minimum and maximum from both ends of the table, or zero them when it is empty.
            S_FIN:
            begin
                if (count_reg == '0)
                begin
                    min_next   = '0;
                    max_next   = '0;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    rd_addr    = '0;
                    state_next = S_FIN1;
                end
            end

            S_FIN1:
            begin
                min_next   = rdata_reg;
                rd_addr    = cnt_dec[AW-1:0];
                state_next = S_FIN2;
            end

            S_FIN2:
            begin
                max_next   = rdata_reg;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            done_reg   <= 1'b0;
            found_reg  <= 1'b0;
            idx_reg    <= '0;
            pos_reg    <= '0;
            cmd_reg    <= CMD_INSERT;
            status_reg <= ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            done_reg   <= done_next;
            found_reg  <= found_next;
            idx_reg    <= idx_next;
            pos_reg    <= pos_next;
            cmd_reg    <= cmd_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        value_reg <= value_next;
        min_reg   <= min_next;
        max_reg   <= max_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[rd_addr];
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

    assign result.status      = status_reg;
    assign result.position    = 6'(pos_reg);
    assign result.value       = value_reg;
    assign result.entry_count = 7'(count_reg);
    assign result.smallest    = min_reg;
    assign result.largest     = max_reg;

`include "sorted_array_table_assert.svh"

    `SAT_ASSERT_SAME(a_count_in_range, 1'b1, count_reg <= CAP_CNT)
    `SAT_ASSERT_SAME(a_done_when_idle, done, !busy)
    `SAT_ASSERT_NEXT(a_done_single, done, !done)
    `SAT_ASSERT_NEXT(a_busy_after_start, start && !busy, busy)
    `SAT_ASSERT_SAME(a_full_means_full, done && (status_reg == ST_FULL), count_reg == CAP_CNT)

endmodule
